>>> hdl/slq_pkg.sv
// Shared types and codes for the sorted list queue.
`default_nettype none

package slq_pkg;

  // Operation codes carried in the op field
  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_POP_MIN = 2'd2,
    OP_POP_MAX = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  localparam int unsigned KeyWidth  = 8;
  localparam int unsigned FillWidth = 5;

  // One input item
  typedef struct packed {
    logic [1:0]                 op;
    logic signed [KeyWidth-1:0] key;
  } in_t;

  // One result item
  typedef struct packed {
    logic signed [KeyWidth-1:0] head_key;
    logic                       head_valid;
    logic [FillWidth-1:0]       fill;
    logic [1:0]                 status;
  } out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    load;        // capture the accepted item and set up the pass
    logic    rd;          // issue a read at the scan position
    logic    wr_shift;    // write the read data one place over
    logic    wr_key;      // write the item key at the scan position
    logic    idx_dec;
    logic    idx_inc;
    logic    set_found;
    logic    occ_inc;
    logic    occ_dec;
    logic    set_status;
    status_e status;
    logic    out_load;    // load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_ins;
    logic is_popf;
    logic is_popb;
    logic empty;
    logic full;
    logic at_zero;   // scan position is zero
    logic at_end;    // scan position equals the count
    logic found;
    logic ge;        // read key is not smaller than the item key
    logic eq;        // read key equals the item key
  } stat_t;

endpackage

`default_nettype wire

>>> hdl/sorted_list_queue_unit.sv
// Top level of the sorted list queue: controller plus datapath.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------
//   in      | input     | in_valid_i / in_ready_o   | in_data_i  (in_t)
//   out     | output    | out_valid_o / out_ready_i | out_data_o (out_t)
//
// One operation at a time. Keys sit in a RAM with registered read, so each
// scanned entry is read, then compared and written. Insert scans down from the
// count to the insert position, remove and pop least scan up to the count, and
// pop greatest does not scan.
// Reset clears the count and the handshake state; no clearing pass.
// A finished result waits in the output register while the next item is
// taken; the following result stalls in the controller until that transfer.
`default_nettype none

module sorted_list_queue_unit
  import slq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  cmd_t  cmd;
  stat_t stat;

  slq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  slq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_data_o(out_data_o)
  );

endmodule

`default_nettype wire

>>> hdl/slq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module slq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/slq_dp.sv
// Datapath of the sorted list queue: key store, count, scan index and result register.
`default_nettype none

module slq_dp
  import slq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire in_t  in_data_i,
  input  wire cmd_t cmd_i,
  output stat_t     stat_o,
  output out_t      out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  logic [1:0]                 op_q;
  logic signed [KeyWidth-1:0] key_q;
  logic signed [KeyWidth-1:0] head_q;
  logic [CW-1:0]              occ_q, occ_d;
  logic [CW-1:0]              idx_q, idx_d;
  logic                       found_q, found_d;
  status_e                    status_q, status_d;
  out_t                       out_q;

  logic                is_ins;
  logic [CW-1:0]       idx_m1;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       ram_raddr;
  logic [KeyWidth-1:0] ram_wdata;
  logic [KeyWidth-1:0] ram_rdata;
  logic [CW+4:0]       occ_ext;

  assign is_ins = (op_q == OP_INSERT);
  assign idx_m1 = idx_q - CW'(1);

  // Select addresses: insert scans downward, remove and pop least scan upward
  assign ram_raddr = is_ins ? idx_m1[AW-1:0] : idx_q[AW-1:0];
  assign ram_we    = cmd_i.wr_shift | cmd_i.wr_key;
  assign ram_waddr = (cmd_i.wr_key || is_ins) ? idx_q[AW-1:0] : idx_m1[AW-1:0];
  assign ram_wdata = cmd_i.wr_key ? key_q : ram_rdata;

  slq_ram #(
    .WIDTH(KeyWidth),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Report flags to the controller
  always_comb begin
    stat_o.is_ins  = is_ins;
    stat_o.is_popf = (op_q == OP_POP_MIN);
    stat_o.is_popb = (op_q == OP_POP_MAX);
    stat_o.empty   = (occ_q == '0);
    stat_o.full    = (occ_q == FullCnt);
    stat_o.at_zero = (idx_q == '0);
    stat_o.at_end  = (idx_q == occ_q);
    stat_o.found   = found_q;
    stat_o.ge      = ($signed(ram_rdata) >= key_q);
    stat_o.eq      = ($signed(ram_rdata) == key_q);
  end

  // Next count, index, found flag and status
  always_comb begin
    occ_d    = occ_q;
    idx_d    = idx_q;
    found_d  = found_q;
    status_d = status_q;
    if (cmd_i.load) begin
      found_d  = (in_data_i.op == OP_POP_MIN);
      status_d = ST_OK;
      if (in_data_i.op == OP_INSERT) begin
        idx_d = occ_q;
      end else if (in_data_i.op == OP_POP_MIN) begin
        idx_d = CW'(1);
      end else begin
        idx_d = '0;
      end
    end else begin
      if (cmd_i.idx_dec) idx_d = idx_m1;
      if (cmd_i.idx_inc) idx_d = idx_q + CW'(1);
      if (cmd_i.set_found) found_d = 1'b1;
      if (cmd_i.set_status) status_d = cmd_i.status;
    end
    if (cmd_i.occ_inc) occ_d = occ_q + CW'(1);
    if (cmd_i.occ_dec) occ_d = occ_q - CW'(1);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      idx_q    <= '0;
      found_q  <= 1'b0;
      status_q <= ST_OK;
    end else begin
      occ_q    <= occ_d;
      idx_q    <= idx_d;
      found_q  <= found_d;
      status_q <= status_d;
    end
  end

  // Hold the item payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_data_i.op;
      key_q <= in_data_i.key;
    end
  end

  // Track the least key: any write to the first entry replaces it
  always_ff @(posedge clk_i) begin
    if (ram_we && (ram_waddr == '0)) begin
      head_q <= $signed(ram_wdata);
    end
  end

  // Result register; fill reports the count modulo 32
  assign occ_ext = {5'b0, occ_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.head_key   <= (occ_q != '0) ? head_q : '0;
      out_q.head_valid <= (occ_q != '0);
      out_q.fill       <= occ_ext[FillWidth-1:0];
      out_q.status     <= status_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

>>> hdl/slq_ctrl.sv
// Controller of the sorted list queue: sequences the scan and the handshakes.
`default_nettype none

module slq_ctrl
  import slq_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequence one operation
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.is_ins) begin
          if (stat_i.full) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_FULL;
            state_d          = S_RESP;
          end else if (stat_i.at_zero) begin
            cmd_o.wr_key  = 1'b1;
            cmd_o.occ_inc = 1'b1;
            state_d       = S_RESP;
          end else begin
            cmd_o.rd = 1'b1;
            state_d  = S_EVAL;
          end
        end else if (stat_i.is_popb) begin
          if (stat_i.empty) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_EMPTY;
          end else begin
            cmd_o.occ_dec = 1'b1;
          end
          state_d = S_RESP;
        end else if (stat_i.is_popf && stat_i.empty) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_EMPTY;
          state_d          = S_RESP;
        end else if (stat_i.at_end) begin
          // end of the upward scan
          if (stat_i.found) begin
            cmd_o.occ_dec = 1'b1;
          end else begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_NOT_FOUND;
          end
          state_d = S_RESP;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat_i.is_ins) begin
          // shift keys not smaller than the new key up, drop the new key below them
          if (stat_i.ge) begin
            cmd_o.wr_shift = 1'b1;
            cmd_o.idx_dec  = 1'b1;
            state_d        = S_CHECK;
          end else begin
            cmd_o.wr_key  = 1'b1;
            cmd_o.occ_inc = 1'b1;
            state_d       = S_RESP;
          end
        end else begin
          // close the gap once the match is found
          if (stat_i.found) begin
            cmd_o.wr_shift = 1'b1;
          end else if (stat_i.eq) begin
            cmd_o.set_found = 1'b1;
          end
          cmd_o.idx_inc = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result valid: set on load, drop on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/slq_checker.sv
// Port-level checks of the sorted list queue and their binding.
`default_nettype none

module slq_checker
  import slq_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire in_t  in_data_i,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_data_o
);

  // A waiting result holds until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // An accepted item keeps the input closed in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an operation is in flight");

  // An empty store reports no head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.head_valid |->
      out_data_o.head_key == '0 && out_data_o.fill == '0)
    else $error("empty result carries a head or count");

  // A nonzero count means a head is present
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fill != '0 |-> out_data_o.head_valid)
    else $error("count without head");

  // Pop on empty leaves nothing stored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_EMPTY |-> !out_data_o.head_valid)
    else $error("pop on empty with keys stored");

endmodule

bind sorted_list_queue_unit slq_checker u_slq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

>>> tb/tb_sorted_list_queue_unit.sv
// Self-checking testbench for the sorted list queue unit.
`timescale 1ns / 100ps

module tb_sorted_list_queue_unit;
  import slq_pkg::*;

  localparam int unsigned Depth      = 16;
  localparam int unsigned PhaseItems = 100;
  localparam int unsigned NumPhases  = 13;
  localparam int unsigned HoldOff    = 300;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned Drain      = 60;

  // Mirror of the key store; builds the expected result of every operation
  class queue_scoreboard;
    logic signed [KeyWidth-1:0] keys [Depth];
    int unsigned                count;
    out_t                       expected_q [$];
    int unsigned                errors;
    int unsigned                ops_seen;
    int unsigned                checked;
    int unsigned                full_drops;
    int unsigned                misses;
    int unsigned                empty_pops;

    function new();
      count      = 0;
      errors     = 0;
      ops_seen   = 0;
      checked    = 0;
      full_drops = 0;
      misses     = 0;
      empty_pops = 0;
    endfunction

    // Apply one accepted operation to the mirror and queue its result
    function void note_op(in_t item);
      op_e         op;
      status_e     st;
      int unsigned pos;
      out_t        res;
      op  = op_e'(item.op);
      st  = ST_OK;
      pos = 0;
      ops_seen++;
      case (op)
        OP_INSERT: begin
          if (count >= Depth) begin
            st = ST_FULL;
          end else begin
            while (pos < count && keys[pos] < item.key) pos++;
            for (int unsigned i = count; i > pos; i--) keys[i] = keys[i-1];
            keys[pos] = item.key;
            count++;
          end
        end
        OP_REMOVE: begin
          while (pos < count && keys[pos] != item.key) pos++;
          if (pos >= count) begin
            st = ST_NOT_FOUND;
          end else begin
            for (int unsigned i = pos; i + 1 < count; i++) keys[i] = keys[i+1];
            count--;
          end
        end
        OP_POP_MIN: begin
          if (count == 0) begin
            st = ST_EMPTY;
          end else begin
            for (int unsigned i = 0; i + 1 < count; i++) keys[i] = keys[i+1];
            count--;
          end
        end
        default: begin
          if (count == 0) st = ST_EMPTY;
          else count--;
        end
      endcase
      case (st)
        ST_FULL:      full_drops++;
        ST_NOT_FOUND: misses++;
        ST_EMPTY:     empty_pops++;
        default: ;
      endcase
      res.head_key   = (count > 0) ? keys[0] : '0;
      res.head_valid = (count > 0);
      res.fill       = FillWidth'(count);
      res.status     = st;
      expected_q = {expected_q, res};
    endfunction

    // Compare one delivered result with the oldest expectation
    function void check_result(out_t got);
      out_t exp;
      if (expected_q.size() == 0) begin
        $error("result with no operation pending: head_key %0d fill %0d status %0d",
               got.head_key, got.fill, got.status);
        errors++;
        return;
      end
      exp = expected_q[0];
      expected_q.delete(0);
      checked++;
      if (got.head_key !== exp.head_key) begin
        $error("head_key: expected %0d, got %0d", exp.head_key, got.head_key);
        errors++;
      end
      if (got.head_valid !== exp.head_valid) begin
        $error("head_valid: expected %0d, got %0d", exp.head_valid, got.head_valid);
        errors++;
      end
      if (got.fill !== exp.fill) begin
        $error("fill: expected %0d, got %0d", exp.fill, got.fill);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  queue_scoreboard sb = new();

  int unsigned pace;          // 0 random gaps, 1 no gaps, 2 occasional gaps
  bit          hold_off_req;
  int unsigned stall_cycles;

  sorted_list_queue_unit #(
    .DEPTH(Depth)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Free-running clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gap before the next transfer on either side, per the current pace
  function automatic int unsigned draw_gap();
    case (pace)
      0:       return $urandom_range(0, 11);
      1:       return 0;
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
    endcase
  endfunction

  // Key mix: full range, a narrow pool so removes hit, and the extremes
  function automatic logic signed [KeyWidth-1:0] pick_key();
    case ($urandom_range(0, 3))
      0:       return KeyWidth'(int'($urandom_range(0, 6)) - 3);
      1:       return $urandom_range(0, 1) ? 8'sh7f : 8'sh80;
      default: return KeyWidth'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic op_e pick_op(int unsigned insert_pct);
    int unsigned r;
    if ($urandom_range(0, 99) < insert_pct) return OP_INSERT;
    r = $urandom_range(0, 9);
    if (r < 4) return OP_REMOVE;
    if (r < 7) return OP_POP_MIN;
    return OP_POP_MAX;
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send_item(op_e op, logic signed [KeyWidth-1:0] key);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{op: op, key: key};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Send a phase of random operations with a given insert bias
  task automatic run_phase(int unsigned insert_pct);
    for (int unsigned n = 0; n < PhaseItems; n++) begin
      send_item(pick_op(insert_pct), pick_key());
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned gap;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldOff) @(posedge clk_i);
      end
      gap = draw_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Observe transfers on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (in_valid_i && in_ready_o) sb.note_op(in_data_i);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("sorted_list_queue_unit verification failed");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned bias [NumPhases] = '{50, 80, 75, 20, 50, 85, 15, 60, 40, 90, 10, 55, 45};
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_ready_i  = 1'b0;
    pace         = 0;
    hold_off_req = 1'b0;
    stall_cycles = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty cases, extremes, duplicates, hit and miss removes
    send_item(OP_POP_MIN, 8'sh55);
    send_item(OP_POP_MAX, -8'sd86);
    send_item(OP_REMOVE,  8'sd0);
    send_item(OP_INSERT,  8'sd0);
    send_item(OP_INSERT,  -8'sd128);
    send_item(OP_INSERT,  8'sd127);
    send_item(OP_INSERT,  8'sd0);
    send_item(OP_INSERT,  -8'sd1);
    send_item(OP_REMOVE,  8'sd0);
    send_item(OP_REMOVE,  8'sd42);
    send_item(OP_POP_MAX, 8'sd0);
    send_item(OP_POP_MIN, -8'sd1);
    send_item(OP_REMOVE,  -8'sd1);
    send_item(OP_REMOVE,  8'sd0);
    send_item(OP_POP_MAX, 8'sd127);
    send_item(OP_POP_MIN, -8'sd128);

    // Random phases that lean to fill or drain, with varied pacing
    for (int unsigned p = 0; p < NumPhases; p++) begin
      pace = p % 3;
      if (p == 2) hold_off_req = 1'b1;
      run_phase(bias[p]);
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);

    $display("Ran %0d operations, checked %0d results.", sb.ops_seen, sb.checked);
    $display("Saw %0d inserts dropped on full, %0d missed removes, %0d pops on empty.",
             sb.full_drops, sb.misses, sb.empty_pops);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sorted_list_queue_unit verification clean");
    end else begin
      $display("sorted_list_queue_unit verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/slq_pkg.sv
hdl/slq_ram.sv
hdl/slq_dp.sv
hdl/slq_ctrl.sv
hdl/sorted_list_queue_unit.sv
hdl/slq_checker.sv
tb/tb_sorted_list_queue_unit.sv
